@@ design/ces_pkg.sv @@
`timescale 1ns / 1ps

package ces_pkg;

    localparam int WHITE_DEPTH_DEF = 16;
    localparam int PREFIX_LEN      = 18;

    localparam logic [1:0] ST_REWRITE  = 2'd0;
    localparam logic [1:0] ST_PASS     = 2'd1;
    localparam logic [1:0] ST_CALL_ERR = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_LBRACE  = 8'h7b;
    localparam logic [7:0] CH_RBRACE  = 8'h7d;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;

    localparam logic [1:0] WC_SPACE = 2'd0;
    localparam logic [1:0] WC_TAB   = 2'd1;
    localparam logic [1:0] WC_NL    = 2'd2;

    // where the next output word comes from
    typedef enum logic [2:0] {
        SRC_WHITE,
        SRC_PREFIX,
        SRC_IN,
        SRC_CHAR,
        SRC_MARK
    } src_t;

    typedef struct packed {
        logic       emit;
        src_t       src;
        logic       run_last;
        logic       done_res;
        logic [1:0] status;
        logic       seq_start;
        logic       rd_adv;
        logic       pfx_adv;
        logic       load_char;
        logic       wr_white;
        logic       clr_count;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic count_zero;
        logic count_full;
        logic rep_end;
        logic pfx_end;
    } stat_t;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    endfunction

    function automatic logic [1:0] white_code(input logic [7:0] c);
        logic [1:0] r;
        case (c)
            CH_TAB:  r = WC_TAB;
            CH_NL:   r = WC_NL;
            default: r = WC_SPACE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] white_byte(input logic [1:0] code);
        logic [7:0] r;
        case (code)
            WC_SPACE: r = CH_SPACE;
            WC_TAB:   r = CH_TAB;
            WC_NL:    r = CH_NL;
            default:  r = CH_SPACE;
        endcase
        return r;
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5f);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] keyword_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = 8'h63; // c
            2'd1:    r = 8'h61; // a
            default: r = 8'h6c; // l
        endcase
        return r;
    endfunction

    // "execute procedure "
    function automatic logic [7:0] prefix_char(input logic [4:0] i);
        logic [7:0] r;
        case (i)
            5'd0:    r = 8'h65;
            5'd1:    r = 8'h78;
            5'd2:    r = 8'h65;
            5'd3:    r = 8'h63;
            5'd4:    r = 8'h75;
            5'd5:    r = 8'h74;
            5'd6:    r = 8'h65;
            5'd7:    r = 8'h20;
            5'd8:    r = 8'h70;
            5'd9:    r = 8'h72;
            5'd10:   r = 8'h6f;
            5'd11:   r = 8'h63;
            5'd12:   r = 8'h65;
            5'd13:   r = 8'h64;
            5'd14:   r = 8'h75;
            5'd15:   r = 8'h72;
            5'd16:   r = 8'h65;
            5'd17:   r = 8'h20;
            default: r = 8'h20;
        endcase
        return r;
    endfunction

endpackage

@@ design/ces_dpath.sv @@
`timescale 1ns / 1ps

module ces_dpath #(
    parameter int WHITE_DEPTH = ces_pkg::WHITE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ces_pkg::cmd_t       cmd,
    output ces_pkg::stat_t      stat,
    input  logic [7:0]          in_char,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_char,
    output logic                char_valid,
    output logic                run_last,
    output logic                done_res,
    output logic [1:0]          status
);

    localparam int AW = (WHITE_DEPTH > 1) ? $clog2(WHITE_DEPTH) : 1;
    localparam int CW = $clog2(WHITE_DEPTH + 1);

    logic [1:0]    white_store [WHITE_DEPTH];
    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [1:0]    rd_reg;
    logic [4:0]    pidx_reg;
    logic [7:0]    char_reg;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_code;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       char_valid_reg;
    logic       run_last_reg;
    logic       done_res_reg;
    logic [1:0] status_reg;

    logic [7:0] byte_next;
    logic       cv_next;

    assign wr_addr = count_reg[AW-1:0];
    assign wr_code = ces_pkg::white_code(in_char);

    always_comb
    begin
        if (cmd.seq_start)
            idx_next = '0;
        else if (cmd.rd_adv)
            idx_next = idx_reg + AW'(1);
        else
            idx_next = idx_reg;
    end

    // replay store
    always_ff @(posedge clk)
    begin
        if (cmd.wr_white)
            white_store[wr_addr] <= wr_code;
        // write-first so that a replay starting on the write cycle sees the new entry
        if (cmd.wr_white && wr_addr == idx_next)
            rd_reg <= wr_code;
        else
            rd_reg <= white_store[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            pidx_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_count)
                count_reg <= '0;
            else if (cmd.wr_white)
                count_reg <= count_reg + CW'(1);
            idx_reg <= idx_next;
            if (cmd.seq_start)
                pidx_reg <= '0;
            else if (cmd.pfx_adv)
                pidx_reg <= pidx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
            char_reg <= in_char;
    end

    always_comb
    begin
        cv_next = 1'b1;
        case (cmd.src)
            ces_pkg::SRC_WHITE:  byte_next = ces_pkg::white_byte(rd_reg);
            ces_pkg::SRC_PREFIX: byte_next = ces_pkg::prefix_char(pidx_reg);
            ces_pkg::SRC_IN:     byte_next = in_char;
            ces_pkg::SRC_CHAR:   byte_next = char_reg;
            default:
            begin
                byte_next = 8'd0;
                cv_next   = 1'b0;
            end
        endcase
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg   <= byte_next;
            char_valid_reg <= cv_next;
            run_last_reg   <= cmd.run_last;
            done_res_reg   <= cmd.done_res;
            status_reg     <= cmd.status;
        end
    end

    assign stat.slot_free  = !out_valid_reg || out_ready;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg == CW'(WHITE_DEPTH));
    assign stat.rep_end    = (CW'(idx_reg) == count_reg - CW'(1));
    assign stat.pfx_end    = (pidx_reg == 5'(ces_pkg::PREFIX_LEN - 1));

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign char_valid = char_valid_reg;
    assign run_last   = run_last_reg;
    assign done_res   = done_res_reg;
    assign status     = status_reg;

endmodule

@@ design/ces_ctrl.sv @@
`timescale 1ns / 1ps

module ces_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_char,
    input  logic            last,
    input  ces_pkg::stat_t  stat,
    output ces_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_KEY,
        PH_COPY,
        PH_QUOTE,
        PH_PASS,
        PH_IGNORE
    } phase_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_REPLAY,
        E_PREFIX,
        E_CHAR,
        E_MARK
    } emit_state_t;

    phase_t      phase_reg, phase_next, ph_n;
    emit_state_t state_reg, state_next;
    logic [2:0]  kw_reg, kw_next, kw_n;
    logic        qd_reg, qd_next, qd_n;
    logic        bs_reg, bs_next, bs_n;
    logic        ovf_reg, ovf_next, ovf_n;

    logic        chr_reg, chr_next;
    logic        fin_reg, fin_next;
    logic        last_reg, last_next;
    logic        rep_reg, rep_next;
    logic        pfx_reg, pfx_next;
    logic [1:0]  st_reg, st_next;

    logic       accept;
    logic       is_w, is_q, kw_ok;
    logic       rep, pfx, chr, fin, mark, to_copy, wr, kw_err, kw_acc;
    logic [1:0] st;
    logic [7:0] close_q;

    assign accept = in_valid && (state_reg == E_IDLE);
    assign is_w   = ces_pkg::is_white(in_char);
    assign is_q   = (in_char == ces_pkg::CH_DQUOTE) || (in_char == ces_pkg::CH_SQUOTE);
    assign kw_ok  = (kw_reg != 3'd4) &&
                    (ces_pkg::to_lower(in_char) == ces_pkg::keyword_char(kw_reg[1:0]));
    assign close_q = qd_reg ? ces_pkg::CH_DQUOTE : ces_pkg::CH_SQUOTE;

    // statement parsing for the word on the input
    always_comb
    begin
        ph_n    = phase_reg;
        kw_n    = kw_reg;
        qd_n    = qd_reg;
        bs_n    = bs_reg;
        ovf_n   = ovf_reg;
        rep     = 1'b0;
        pfx     = 1'b0;
        chr     = 1'b0;
        fin     = 1'b0;
        st      = ces_pkg::ST_REWRITE;
        to_copy = 1'b0;
        wr      = 1'b0;
        kw_err  = 1'b0;
        kw_acc  = 1'b0;
        case (phase_reg)
            PH_LEAD:
            begin
                if (is_w)
                begin
                    wr = !stat.count_full;
                    if (stat.count_full)
                        ovf_n = 1'b1;
                    if (last)
                    begin
                        rep = 1'b1;
                        fin = 1'b1;
                        st  = (ovf_reg || stat.count_full) ? ces_pkg::ST_OVERFLOW
                                                           : ces_pkg::ST_PASS;
                    end
                end
                else if (in_char == ces_pkg::CH_LBRACE)
                begin
                    if (last)
                    begin
                        ph_n = PH_IGNORE;
                        fin  = 1'b1;
                        st   = ces_pkg::ST_CALL_ERR;
                    end
                    else
                        ph_n = PH_KEY;
                end
                else
                begin
                    rep  = !stat.count_zero;
                    chr  = 1'b1;
                    ph_n = PH_PASS;
                    st   = ovf_reg ? ces_pkg::ST_OVERFLOW : ces_pkg::ST_PASS;
                end
            end
            PH_KEY:
            begin
                if (is_w)
                begin
                    if (kw_reg == 3'd4)
                    begin
                        kw_acc  = 1'b1;
                        to_copy = 1'b1;
                    end
                    else if (kw_reg != 3'd0 || last)
                        kw_err = 1'b1;
                end
                else if (ces_pkg::is_ident(in_char))
                begin
                    if (kw_ok)
                    begin
                        kw_n = kw_reg + 3'd1;
                        if (last)
                        begin
                            if (kw_reg == 3'd3)
                                kw_acc = 1'b1;
                            else
                                kw_err = 1'b1;
                        end
                    end
                    else
                        kw_err = 1'b1;
                end
                else if (kw_reg == 3'd4)
                begin
                    kw_acc  = 1'b1;
                    to_copy = 1'b1;
                end
                else
                    kw_err = 1'b1;
                if (kw_err)
                begin
                    ph_n = PH_IGNORE;
                    fin  = 1'b1;
                    st   = ces_pkg::ST_CALL_ERR;
                end
                if (kw_acc)
                begin
                    pfx  = 1'b1;
                    ph_n = PH_COPY;
                end
            end
            PH_COPY:
                to_copy = 1'b1;
            PH_QUOTE:
            begin
                chr = 1'b1;
                // a backslash just before the quote keeps the run open
                if (in_char == close_q && !bs_reg)
                begin
                    ph_n = PH_COPY;
                    bs_n = 1'b0;
                end
                else
                    bs_n = (in_char == ces_pkg::CH_BSLASH);
            end
            PH_PASS:
            begin
                chr = 1'b1;
                st  = ovf_reg ? ces_pkg::ST_OVERFLOW : ces_pkg::ST_PASS;
            end
            default:
            begin
            end
        endcase

        if (to_copy && !is_w)
        begin
            if (in_char == ces_pkg::CH_RBRACE)
            begin
                ph_n = PH_IGNORE;
                fin  = 1'b1;
            end
            else
            begin
                chr = 1'b1;
                if (is_q)
                begin
                    ph_n = PH_QUOTE;
                    qd_n = (in_char == ces_pkg::CH_DQUOTE);
                    bs_n = 1'b0;
                end
            end
        end

        if (last && !fin && ph_n != PH_IGNORE)
            fin = 1'b1;
        mark = fin && !rep && !pfx && !chr;
    end

    // result sequencing
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        kw_next    = kw_reg;
        qd_next    = qd_reg;
        bs_next    = bs_reg;
        ovf_next   = ovf_reg;
        rep_next   = rep_reg;
        pfx_next   = pfx_reg;
        chr_next   = chr_reg;
        fin_next   = fin_reg;
        last_next  = last_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.src    = ces_pkg::SRC_MARK;
        cmd.status = st_reg;
        in_ready   = (state_reg == E_IDLE);

        case (state_reg)
            E_IDLE:
            begin
                if (accept)
                begin
                    cmd.seq_start = 1'b1;
                    cmd.load_char = 1'b1;
                    cmd.wr_white  = wr;
                    cmd.clr_count = last && !rep;
                    if (last)
                    begin
                        phase_next = PH_LEAD;
                        kw_next    = '0;
                        qd_next    = 1'b0;
                        bs_next    = 1'b0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        phase_next = ph_n;
                        kw_next    = kw_n;
                        qd_next    = qd_n;
                        bs_next    = bs_n;
                        ovf_next   = ovf_n;
                    end
                    rep_next  = rep;
                    pfx_next  = pfx;
                    chr_next  = chr;
                    fin_next  = fin;
                    last_next = last;
                    st_next   = st;
                    if (!rep && !pfx && (chr || mark) && stat.slot_free)
                    begin
                        // single word goes straight to the output register
                        cmd.emit     = 1'b1;
                        cmd.src      = chr ? ces_pkg::SRC_IN : ces_pkg::SRC_MARK;
                        cmd.run_last = 1'b1;
                        cmd.done_res = fin;
                        cmd.status   = st;
                    end
                    else if (rep)
                        state_next = E_REPLAY;
                    else if (pfx)
                        state_next = E_PREFIX;
                    else if (chr)
                        state_next = E_CHAR;
                    else if (mark)
                        state_next = E_MARK;
                end
            end
            E_REPLAY:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.src      = ces_pkg::SRC_WHITE;
                    cmd.run_last = stat.rep_end && !chr_reg;
                    cmd.done_res = stat.rep_end && !chr_reg && fin_reg;
                    if (stat.rep_end)
                    begin
                        cmd.clr_count = last_reg;
                        state_next    = chr_reg ? E_CHAR : E_IDLE;
                    end
                    else
                        cmd.rd_adv = 1'b1;
                end
            end
            E_PREFIX:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.src      = ces_pkg::SRC_PREFIX;
                    cmd.run_last = stat.pfx_end && !chr_reg;
                    cmd.done_res = stat.pfx_end && !chr_reg && fin_reg;
                    if (stat.pfx_end)
                        state_next = chr_reg ? E_CHAR : E_IDLE;
                    else
                        cmd.pfx_adv = 1'b1;
                end
            end
            E_CHAR:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.src      = ces_pkg::SRC_CHAR;
                    cmd.run_last = 1'b1;
                    cmd.done_res = fin_reg;
                    state_next   = E_IDLE;
                end
            end
            E_MARK:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.src      = ces_pkg::SRC_MARK;
                    cmd.run_last = 1'b1;
                    cmd.done_res = fin_reg;
                    state_next   = E_IDLE;
                end
            end
            default:
                state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            phase_reg <= PH_LEAD;
            kw_reg    <= '0;
            qd_reg    <= 1'b0;
            bs_reg    <= 1'b0;
            ovf_reg   <= 1'b0;
            rep_reg   <= 1'b0;
            pfx_reg   <= 1'b0;
            chr_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            last_reg  <= 1'b0;
            st_reg    <= ces_pkg::ST_REWRITE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kw_reg    <= kw_next;
            qd_reg    <= qd_next;
            bs_reg    <= bs_next;
            ovf_reg   <= ovf_next;
            rep_reg   <= rep_next;
            pfx_reg   <= pfx_next;
            chr_reg   <= chr_next;
            fin_reg   <= fin_next;
            last_reg  <= last_next;
            st_reg    <= st_next;
        end
    end

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.slot_free)
        else $error("word emitted into a full output register");

    a_replay_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_REPLAY) |-> !stat.count_zero)
        else $error("replay with an empty whitespace store");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> (phase_reg == PH_LEAD && kw_reg == 3'd0))
        else $error("statement state not cleared after last word");

    a_plan_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(rep_reg && pfx_reg))
        else $error("replay and prefix planned for the same word");

    a_prefix_only_rewrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_PREFIX) |-> (st_reg == ces_pkg::ST_REWRITE))
        else $error("prefix emitted with a non-rewrite status");

endmodule

@@ design/call_escape_rewriter_core.sv @@
`timescale 1ns / 1ps

// Rewrites a call escape statement "{call name(...)}" into "execute procedure name(...)";
// a statement without the brace passes through, a malformed escape yields a call error.
// Input channel (in_valid/in_ready): one statement byte per word in in_char, last marks
// the final byte of the statement. Output channel (out_valid/out_ready): one word per
// result byte; char_valid 0 marks a bare end marker, run_last flags the final word caused
// by an input word, done_res the final word of the statement, status the outcome.
// A word that yields at most one output word and no whitespace replay is taken every
// cycle while the receiver keeps up; the output sits one register after the accepting edge.
// A word that replays k stored leading whitespace bytes (up to WHITE_DEPTH, plus the byte
// itself on a pass-through) or the 18-byte prefix and at most one byte holds in_ready low
// until its last word is emitted, one output word per cycle from the sequencer while the
// receiver keeps up; the whitespace store is read through a registered port.
// When the receiver stalls, the output register holds its word and the sequencer waits;
// a new input word is still taken while the output register is full.
// Reset clears the sequencer, the statement state and the output valid; the whitespace
// store needs no clearing since only entries written in the current statement are read.

module call_escape_rewriter_core #(
    parameter int WHITE_DEPTH = ces_pkg::WHITE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       char_valid,
    output logic       run_last,
    output logic       done_res,
    output logic [1:0] status
);

    ces_pkg::cmd_t  cmd;
    ces_pkg::stat_t stat;

    ces_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_char  (in_char),
        .last     (last),
        .stat     (stat),
        .cmd      (cmd)
    );

    ces_dpath #(
        .WHITE_DEPTH (WHITE_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_char    (in_char),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_char   (out_char),
        .char_valid (char_valid),
        .run_last   (run_last),
        .done_res   (done_res),
        .status     (status)
    );

endmodule

@@ bench/call_escape_rewriter_core_tb.sv @@
`timescale 1ns / 1ps

module call_escape_rewriter_core_tb;

    localparam int HOLD_CYCLES = 500;
    localparam int STALL_LIMIT = 3000;
    localparam int CYCLE_CAP   = 1000000;
    localparam int TAIL_CYCLES = 40;
    localparam int PRINT_CAP   = 50;

    typedef enum logic [2:0] {
        P_LEAD,
        P_KEY,
        P_COPY,
        P_QUOTE,
        P_PASS,
        P_IGNORE
    } stmt_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } in_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       cv;
        logic       rl;
        logic       dn;
        logic [1:0] st;
    } out_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_char = ces_pkg::CH_SPACE;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       done_res;
    logic [1:0] status;

    in_word_t   pending_words [$];
    out_word_t  expected_words [$];
    logic [7:0] stmt_bytes [$];
    int         queued_bytes = 0;
    int         mismatch_count = 0;
    int         stall_cycles = 0;
    int         total_cycles = 0;
    int         send_idle_pct = 10;
    int         recv_idle_pct = 62;
    bit         hold_req = 1'b0;
    bit         hold_taken = 1'b0;
    int         hold_cnt = 0;

    // statement state of the rewriter as predicted
    stmt_phase_t ph = P_LEAD;
    logic [1:0]  wstore [ces_pkg::WHITE_DEPTH_DEF];
    int          wcount = 0;
    int          kmatch = 0;
    bit          qdouble = 1'b0;
    bit          prev_bs = 1'b0;
    bit          wovf = 1'b0;

    string prefix_text  = "execute procedure ";
    string keyword_text = "call";
    string punct_text   = "?=(),";

    call_escape_rewriter_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_char    (in_char),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .char_valid (char_valid),
        .run_last   (run_last),
        .done_res   (done_res),
        .status     (status)
    );

    always #1 clk = ~clk;

    function automatic int white_index(input logic [7:0] c);
        int r;
        r = -1;
        if (c == ces_pkg::CH_SPACE) r = 0;
        else if (c == ces_pkg::CH_TAB) r = 1;
        else if (c == ces_pkg::CH_NL) r = 2;
        return r;
    endfunction

    function automatic logic [7:0] white_char(input logic [1:0] code);
        logic [7:0] r;
        case (code)
            ces_pkg::WC_SPACE: r = ces_pkg::CH_SPACE;
            ces_pkg::WC_TAB:   r = ces_pkg::CH_TAB;
            default:           r = ces_pkg::CH_NL;
        endcase
        return r;
    endfunction

    function automatic bit word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_";
    endfunction

    function automatic logic [7:0] lower_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // works out the words that one accepted input word causes
    task automatic predict_outputs(input logic [7:0] c, input logic lst);
        logic [7:0] emit_q [$];
        logic [1:0] st;
        bit         fin, to_copy, replay, accept, bad;
        int         wc, total, i;
        out_word_t  w;
        st = ces_pkg::ST_REWRITE;
        fin = 1'b0;
        to_copy = 1'b0;
        replay = 1'b0;
        accept = 1'b0;
        bad = 1'b0;
        wc = white_index(c);
        case (ph)
            P_LEAD:
            begin
                if (wc >= 0)
                begin
                    if (wcount < ces_pkg::WHITE_DEPTH_DEF)
                    begin
                        wstore[wcount] = wc[1:0];
                        wcount++;
                    end
                    else
                    begin
                        wovf = 1'b1;
                    end
                    if (lst)
                    begin
                        replay = 1'b1;
                        fin = 1'b1;
                    end
                end
                else if (c == ces_pkg::CH_LBRACE)
                begin
                    ph = P_KEY;
                    if (lst)
                    begin
                        ph = P_IGNORE;
                        fin = 1'b1;
                        st = ces_pkg::ST_CALL_ERR;
                    end
                end
                else
                begin
                    replay = 1'b1;
                    ph = P_PASS;
                end
                if (replay)
                begin
                    st = wovf ? ces_pkg::ST_OVERFLOW : ces_pkg::ST_PASS;
                    for (i = 0; i < wcount; i++)
                        emit_q.push_back(white_char(wstore[i]));
                    if (ph == P_PASS)
                        emit_q.push_back(c);
                end
            end
            P_KEY:
            begin
                if (wc >= 0)
                begin
                    if (kmatch == 4)
                    begin
                        accept = 1'b1;
                        to_copy = 1'b1;
                    end
                    else if (kmatch != 0 || lst)
                    begin
                        bad = 1'b1;
                    end
                end
                else if (word_char(c))
                begin
                    if (kmatch < 4 && lower_char(c) == keyword_text[kmatch])
                    begin
                        kmatch++;
                        if (lst)
                        begin
                            if (kmatch == 4) accept = 1'b1;
                            else bad = 1'b1;
                        end
                    end
                    else
                    begin
                        bad = 1'b1;
                    end
                end
                else if (kmatch == 4)
                begin
                    accept = 1'b1;
                    to_copy = 1'b1;
                end
                else
                begin
                    bad = 1'b1;
                end
                if (bad)
                begin
                    ph = P_IGNORE;
                    fin = 1'b1;
                    st = ces_pkg::ST_CALL_ERR;
                end
                if (accept)
                begin
                    for (i = 0; i < ces_pkg::PREFIX_LEN; i++)
                        emit_q.push_back(prefix_text[i]);
                    ph = P_COPY;
                    st = ces_pkg::ST_REWRITE;
                end
            end
            P_COPY:
            begin
                to_copy = 1'b1;
            end
            P_QUOTE:
            begin
                emit_q.push_back(c);
                if (c == (qdouble ? ces_pkg::CH_DQUOTE : ces_pkg::CH_SQUOTE) && !prev_bs)
                begin
                    ph = P_COPY;
                    prev_bs = 1'b0;
                end
                else
                begin
                    prev_bs = (c == ces_pkg::CH_BSLASH);
                end
            end
            P_PASS:
            begin
                emit_q.push_back(c);
                st = wovf ? ces_pkg::ST_OVERFLOW : ces_pkg::ST_PASS;
            end
            default:
            begin
            end
        endcase

        // copy phase: white outside quotes is dropped, a closing brace ends the output
        if (to_copy && wc < 0)
        begin
            if (c == ces_pkg::CH_RBRACE)
            begin
                ph = P_IGNORE;
                fin = 1'b1;
            end
            else
            begin
                emit_q.push_back(c);
                if (c == ces_pkg::CH_DQUOTE || c == ces_pkg::CH_SQUOTE)
                begin
                    ph = P_QUOTE;
                    qdouble = (c == ces_pkg::CH_DQUOTE);
                    prev_bs = 1'b0;
                end
            end
        end

        if (lst && !fin && ph != P_IGNORE)
            fin = 1'b1;

        total = emit_q.size();
        if (fin && total == 0)
            total = 1;
        for (i = 0; i < total; i++)
        begin
            w.ch = (i < emit_q.size()) ? emit_q[i] : 8'h00;
            w.cv = (i < emit_q.size());
            w.rl = (i == total - 1);
            w.dn = fin && (i == total - 1);
            w.st = st;
            expected_words.push_back(w);
        end

        if (lst)
        begin
            ph = P_LEAD;
            wcount = 0;
            kmatch = 0;
            qdouble = 1'b0;
            prev_bs = 1'b0;
            wovf = 1'b0;
        end
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            stmt_bytes.push_back(s[i]);
    endtask

    task automatic flush_stmt();
        in_word_t w;
        int       i;
        for (i = 0; i < stmt_bytes.size(); i++)
        begin
            w.ch = stmt_bytes[i];
            w.lst = (i == stmt_bytes.size() - 1);
            pending_words.push_back(w);
        end
        queued_bytes += stmt_bytes.size();
        stmt_bytes.delete();
    endtask

    function automatic logic [7:0] pick_white();
        logic [7:0] r;
        case ($urandom_range(2))
            0:       r = ces_pkg::CH_SPACE;
            1:       r = ces_pkg::CH_TAB;
            default: r = ces_pkg::CH_NL;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(255, 1));
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] r;
        case ($urandom_range(11))
            0, 1:    r = 8'($urandom_range(8'h7a, 8'h61));
            2:       r = 8'($urandom_range(8'h5a, 8'h41));
            3:       r = ($urandom_range(3) == 0) ? 8'h5f : 8'($urandom_range(8'h39, 8'h30));
            4:       r = punct_text[$urandom_range(punct_text.len() - 1)];
            5:       r = pick_white();
            6:       r = ces_pkg::CH_SQUOTE;
            7:       r = ces_pkg::CH_DQUOTE;
            8:       r = ces_pkg::CH_BSLASH;
            9:       r = any_char();
            10:      r = ces_pkg::CH_RBRACE;
            default: r = 8'($urandom_range(8'h7a, 8'h61));
        endcase
        return r;
    endfunction

    // mostly well formed call escapes with random content, some pass-through and broken ones
    task automatic gen_stmt();
        int         kind, nw, nb, j;
        logic [7:0] k;
        nw = ($urandom_range(9) == 0) ? $urandom_range(20, 15) : $urandom_range(3);
        for (j = 0; j < nw; j++)
            stmt_bytes.push_back(pick_white());
        kind = $urandom_range(99);
        if (kind < 60)
        begin
            stmt_bytes.push_back(ces_pkg::CH_LBRACE);
            if ($urandom_range(3) == 0)
                stmt_bytes.push_back(pick_white());
            for (j = 0; j < 4; j++)
            begin
                k = keyword_text[j];
                if ($urandom_range(1)) k = k - 8'd32;
                stmt_bytes.push_back(k);
            end
            nb = $urandom_range(10);
            for (j = 0; j < nb; j++)
                stmt_bytes.push_back(body_char());
            if ($urandom_range(9) != 0)
                stmt_bytes.push_back(ces_pkg::CH_RBRACE);
            if ($urandom_range(4) == 0)
                stmt_bytes.push_back(any_char());
        end
        else if (kind < 80)
        begin
            nb = $urandom_range(8, 1);
            for (j = 0; j < nb; j++)
                stmt_bytes.push_back(any_char());
        end
        else
        begin
            stmt_bytes.push_back(ces_pkg::CH_LBRACE);
            nb = $urandom_range(4);
            for (j = 0; j < nb; j++)
            begin
                k = keyword_text[j];
                if ($urandom_range(1)) k = k - 8'd32;
                stmt_bytes.push_back(k);
            end
            nb = $urandom_range(3);
            for (j = 0; j < nb; j++)
                stmt_bytes.push_back(($urandom_range(1) == 0) ? body_char() : any_char());
        end
        flush_stmt();
    endtask

    // sender: a word stays put until it is taken
    always @(posedge clk)
    begin : drive_words
        in_word_t w;
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = pending_words.pop_front();
                    in_valid <= 1'b1;
                    in_char <= w.ch;
                    last <= w.lst;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cnt != 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_ready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_cnt <= HOLD_CYCLES;
                hold_taken <= 1'b1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_words
        out_word_t e;
        bit        moved;
        total_cycles++;
        moved = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word out_char %h", out_char));
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (out_char !== e.ch)
                        report_mismatch($sformatf("out_char %h, expected %h", out_char, e.ch));
                    if (char_valid !== e.cv)
                        report_mismatch($sformatf("char_valid %b, expected %b",
                                                  char_valid, e.cv));
                    if (run_last !== e.rl)
                        report_mismatch($sformatf("run_last %b, expected %b", run_last, e.rl));
                    if (done_res !== e.dn)
                        report_mismatch($sformatf("done_res %b, expected %b", done_res, e.dn));
                    if (status !== e.st)
                        report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
                end
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                predict_outputs(in_char, last);
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    initial
    begin : run_ctrl
        bit timed_out;
        int target, i;
        timed_out = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        fork
            begin
                // directed statements
                add_text("{call p(?,?)}");
                flush_stmt();
                add_text(" \t\nselect 1");
                flush_stmt();
                for (i = 0; i < ces_pkg::WHITE_DEPTH_DEF + 1; i++)
                    stmt_bytes.push_back(ces_pkg::CH_TAB);
                add_text("x");
                flush_stmt();
                add_text(" \t ");
                flush_stmt();
                add_text("{CaLL x('a\\'b', \"q\" )}");
                flush_stmt();
                add_text("{calx}");
                flush_stmt();
                add_text("{cal}");
                flush_stmt();
                add_text("{callz}");
                flush_stmt();
                add_text("{ call\tf}tail");
                flush_stmt();
                add_text("{");
                flush_stmt();
                add_text("{cal");
                flush_stmt();
                add_text("{#");
                flush_stmt();
                add_text("{CALL");
                flush_stmt();
                add_text("{call\"a b");
                flush_stmt();
                add_text("{call f ");
                flush_stmt();
                add_text("{call}");
                flush_stmt();
                stmt_bytes.push_back(8'h01);
                stmt_bytes.push_back(8'hff);
                stmt_bytes.push_back(8'h80);
                flush_stmt();

                target = queued_bytes + 60;
                while (queued_bytes < target) gen_stmt();
                while (pending_words.size() != 0) @(negedge clk);

                send_idle_pct = 62;
                recv_idle_pct = 10;
                target = queued_bytes + 60;
                while (queued_bytes < target) gen_stmt();
                while (pending_words.size() != 0) @(negedge clk);

                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req = 1'b1;
                target = queued_bytes + 60;
                while (queued_bytes < target) gen_stmt();

                while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
                    @(negedge clk);
                repeat (TAIL_CYCLES) @(negedge clk);
            end
            begin
                while (stall_cycles < STALL_LIMIT && total_cycles < CYCLE_CAP)
                    @(negedge clk);
                timed_out = 1'b1;
            end
        join_any
        if (timed_out)
            $display("CHECK FAILED");
        else if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
